FILE: src/crm_pkg.sv
package crm_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CNT_W      = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam int OP_W       = 3;
    localparam int REP_W      = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_ONE   = {{(CNT_W-1){1'b0}}, 1'b1};

    localparam logic [OP_W-1:0] OP_INC    = 3'd0;
    localparam logic [OP_W-1:0] OP_DEC    = 3'd1;
    localparam logic [OP_W-1:0] OP_RIGHT  = 3'd2;
    localparam logic [OP_W-1:0] OP_LEFT   = 3'd3;
    localparam logic [OP_W-1:0] OP_OUTPUT = 3'd4;
    localparam logic [OP_W-1:0] OP_INPUT  = 3'd5;
    localparam logic [OP_W-1:0] OP_OPEN   = 3'd6;
    localparam logic [OP_W-1:0] OP_CLOSE  = 3'd7;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;

    typedef struct packed {
        logic            is_end;
        logic [OP_W-1:0] op;
    } cmd_t;

endpackage

FILE: src/command_run_merger.sv
// channel   direction  handshake       payload
// input     in         push / full     char_code, end_of_stream
// result    out        empty / pop     op_code, repeat_count, end_marker
//
// one command transaction per cycle is taken while full is low and merged in the back stage
// an end transaction with a pending run first flushes the run, then emits the end marker
// reset clears the run, the command queue and the result valid flag
// a stalled result side fills the four-entry command queue before full rises
module command_run_merger (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                char_code,
    input  logic                      end_of_stream,
    output logic                      empty,
    input  logic                      pop,
    output logic [crm_pkg::OP_W-1:0]  op_code,
    output logic [crm_pkg::REP_W-1:0] repeat_count,
    output logic                      end_marker
);
    import crm_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic head_valid;
    cmd_t head;
    logic head_take;

    crm_front u_front (
        .char_code     (char_code),
        .end_of_stream (end_of_stream),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd)
    );

    crm_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (push & cmd_valid),
        .wr_data    (cmd),
        .full       (full),
        .rd_en      (head_take),
        .head_valid (head_valid),
        .head       (head)
    );

    crm_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .head_take    (head_take),
        .empty        (empty),
        .pop          (pop),
        .op_code      (op_code),
        .repeat_count (repeat_count),
        .end_marker   (end_marker)
    );

endmodule

FILE: src/crm_front.sv
module crm_front (
    input  logic [7:0]   char_code,
    input  logic         end_of_stream,
    output logic         cmd_valid,
    output crm_pkg::cmd_t cmd
);
    import crm_pkg::*;

    logic            known;
    logic [OP_W-1:0] op;

    always_comb
    begin
        known = 1'b1;
        op    = OP_INC;
        case (char_code)
            CH_PLUS:  op = OP_INC;
            CH_MINUS: op = OP_DEC;
            CH_GT:    op = OP_RIGHT;
            CH_LT:    op = OP_LEFT;
            CH_DOT:   op = OP_OUTPUT;
            CH_COMMA: op = OP_INPUT;
            CH_LBRK:  op = OP_OPEN;
            CH_RBRK:  op = OP_CLOSE;
            default:  known = 1'b0;
        endcase
    end

    // end items always pass, other bytes only when they are commands
    assign cmd_valid  = end_of_stream | known;
    assign cmd.is_end = end_of_stream;
    assign cmd.op     = end_of_stream ? OP_INC : op;

endmodule

FILE: src/crm_cmd_queue.sv
module crm_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  crm_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          head_valid,
    output crm_pkg::cmd_t head
);
    import crm_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_wr      = wr_en & ~full;
    assign do_rd      = rd_en & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/crm_merge.sv
module crm_merge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  crm_pkg::cmd_t             head,
    output logic                      head_take,
    output logic                      empty,
    input  logic                      pop,
    output logic [crm_pkg::OP_W-1:0]  op_code,
    output logic [crm_pkg::REP_W-1:0] repeat_count,
    output logic                      end_marker
);
    import crm_pkg::*;

    logic             run_valid_reg, run_valid_next;
    logic [OP_W-1:0]  run_op_reg, run_op_next;
    logic [CNT_W-1:0] run_count_reg, run_count_next;

    logic             out_valid_reg, out_valid_next;
    logic [OP_W-1:0]  out_op_reg, out_op_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic             out_end_reg, out_end_next;

    logic can_emit, need_emit, act;
    logic same_op, cancel_op;

    assign can_emit  = ~out_valid_reg | pop;
    assign same_op   = (head.op == run_op_reg) && (head.op < OP_OPEN)
                       && (run_count_reg != COUNT_LIMIT);
    assign cancel_op = (head.op < OP_OUTPUT) && (run_op_reg < OP_OUTPUT)
                       && (head.op != run_op_reg)
                       && (head.op[2:1] == run_op_reg[2:1]);
    assign need_emit = head.is_end | (run_valid_reg & ~same_op & ~cancel_op);
    assign act       = head_valid & (~need_emit | can_emit);

    always_comb
    begin
        run_valid_next = run_valid_reg;
        run_op_next    = run_op_reg;
        run_count_next = run_count_reg;
        out_valid_next = out_valid_reg & ~pop;
        out_op_next    = out_op_reg;
        out_count_next = out_count_reg;
        out_end_next   = out_end_reg;
        head_take      = 1'b0;
        if (act)
        begin
            if (head.is_end)
            begin
                out_valid_next = 1'b1;
                if (run_valid_reg)
                begin
                    // flush first, the end transaction stays at the head
                    out_op_next    = run_op_reg;
                    out_count_next = run_count_reg;
                    out_end_next   = 1'b0;
                    run_valid_next = 1'b0;
                end
                else
                begin
                    out_op_next    = OP_INC;
                    out_count_next = '0;
                    out_end_next   = 1'b1;
                    run_op_next    = OP_INC;
                    run_count_next = '0;
                    head_take      = 1'b1;
                end
            end
            else
            begin
                head_take = 1'b1;
                if (!run_valid_reg)
                begin
                    run_valid_next = 1'b1;
                    run_op_next    = head.op;
                    run_count_next = COUNT_ONE;
                end
                else if (same_op)
                begin
                    run_count_next = run_count_reg + 1'b1;
                end
                else if (cancel_op)
                begin
                    if (run_count_reg > COUNT_ONE)
                    begin
                        run_count_next = run_count_reg - 1'b1;
                    end
                    else
                    begin
                        run_valid_next = 1'b0;
                        run_op_next    = OP_INC;
                        run_count_next = '0;
                    end
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_op_next    = run_op_reg;
                    out_count_next = run_count_reg;
                    out_end_next   = 1'b0;
                    run_op_next    = head.op;
                    run_count_next = COUNT_ONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            run_op_reg    <= OP_INC;
            run_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_valid_reg <= run_valid_next;
            run_op_reg    <= run_op_next;
            run_count_reg <= run_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_op_reg    <= out_op_next;
        out_count_reg <= out_count_next;
        out_end_reg   <= out_end_next;
    end

    assign empty        = ~out_valid_reg;
    assign op_code      = out_op_reg;
    assign repeat_count = REP_W'(out_count_reg);
    assign end_marker   = out_end_reg;

endmodule
